FILE: rtl/crrip_pkg.sv
// shared types and constants for the criticality-aware rrip replacement block
`default_nettype none

package crrip_pkg;

	// access kinds; the fourth code is unused and changes nothing
	typedef enum logic [1:0] {
		KIND_QUERY = 2'd0,
		KIND_HIT   = 2'd1,
		KIND_FILL  = 2'd2
	} kind_t;

	// criticality value that marks a critical line
	localparam logic [7:0] CRIT_MARK = 8'hFF;

	// fixed field widths
	localparam int unsigned SET_W  = 11;
	localparam int unsigned WAY_W  = 4;
	localparam int unsigned CRIT_W = 8;

	// command held for the row update
	typedef struct packed {
		logic [1:0]        kind;
		logic [WAY_W-1:0]  way;
		logic [CRIT_W-1:0] crit;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/crrip_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none

module crrip_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 2048
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/crrip_row_update.sv
// read-modify logic for one set row: aging, victim search, hit and fill updates
`default_nettype none

module crrip_row_update #(
	parameter int unsigned WAYS     = 16,
	parameter int unsigned RRPV_MAX = 3
) (
	input  wire crrip_pkg::cmd_t                                  cmd,
	input  wire logic [WAYS*$clog2(RRPV_MAX+1)-1:0]               row_in,
	output logic      [WAYS*$clog2(RRPV_MAX+1)-1:0]               row_out,
	output logic      [crrip_pkg::WAY_W-1:0]                      victim
);

	import crrip_pkg::*;

	localparam int unsigned RW = $clog2(RRPV_MAX + 1);
	localparam logic [RW-1:0] MAXV      = RW'(RRPV_MAX);
	localparam logic [RW-1:0] FILL_CRIT = RW'(RRPV_MAX - 1);
	localparam logic [RW-1:0] FILL_NORM = (RRPV_MAX >= 2) ? RW'(RRPV_MAX - 2) : '0;

	logic [RRPV_MAX:0] present;
	logic [RW-1:0]     largest;
	logic [RW-1:0]     lift;
	logic [RW-1:0]     fill_val;

	// which prediction values occur in the row
	always_comb begin
		present = '0;
		for (int v = 0; v <= int'(RRPV_MAX); v++) begin
			for (int w = 0; w < int'(WAYS); w++) begin
				if (row_in[w*RW +: RW] == RW'(v)) begin
					present[v] = 1'b1;
				end
			end
		end
	end

	// largest value, then the lift that brings it to the maximum
	always_comb begin
		largest = '0;
		for (int v = 0; v <= int'(RRPV_MAX); v++) begin
			if (present[v]) begin
				largest = RW'(v);
			end
		end
		lift = MAXV - largest;
	end

	// lowest way holding the largest value ends at the maximum after aging
	always_comb begin
		victim = '0;
		for (int w = int'(WAYS) - 1; w >= 0; w--) begin
			if (row_in[w*RW +: RW] == largest) begin
				victim = WAY_W'(w);
			end
		end
	end

	assign fill_val = (cmd.crit == CRIT_MARK) ? FILL_CRIT : FILL_NORM;

	// new row; a way beyond the row matches no entry and leaves it unchanged
	always_comb begin
		row_out = row_in;
		case (cmd.kind)
			KIND_QUERY: begin
				for (int w = 0; w < int'(WAYS); w++) begin
					row_out[w*RW +: RW] = row_in[w*RW +: RW] + lift;
				end
			end
			KIND_HIT: begin
				for (int w = 0; w < int'(WAYS); w++) begin
					if (int'(cmd.way) == w) begin
						row_out[w*RW +: RW] = '0;
					end
				end
			end
			KIND_FILL: begin
				for (int w = 0; w < int'(WAYS); w++) begin
					if (int'(cmd.way) == w) begin
						row_out[w*RW +: RW] = fill_val;
					end
				end
			end
			default: begin
				row_out = row_in;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/criticality_rrip_replacement.sv
// top level of the criticality-aware static rrip replacement block
`default_nettype none

// Replacement state is one row per set in a single ram, RRPV values of all
// ways packed side by side. After reset the block runs a clearing pass that
// writes every row to the maximum value, one row a cycle, with busy high.
// Each accepted item then passes through latch, set-index reduction
// (reciprocal multiply), row read, and modify with write-back; busy drops
// in the cycle after the write, so a new item can be taken only once the
// last one is through, bounded by the single read-then-write pass on the
// row ram. A victim query drives result_valid for one cycle, the cycle after
// its write-back; results cannot be held off and must be taken when shown.
module criticality_rrip_replacement #(
	parameter int unsigned SETS     = 2048,
	parameter int unsigned WAYS     = 16,
	parameter int unsigned RRPV_MAX = 3
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    kind,
	input  wire logic [crrip_pkg::SET_W-1:0]   set_index,
	input  wire logic [crrip_pkg::WAY_W-1:0]   way,
	input  wire logic [crrip_pkg::CRIT_W-1:0]  criticality,
	output logic                               result_valid,
	output logic      [crrip_pkg::WAY_W-1:0]   victim_way
);

	import crrip_pkg::*;

	localparam int unsigned RW    = $clog2(RRPV_MAX + 1);
	localparam int unsigned ROW_W = WAYS * RW;
	localparam int unsigned AW    = (SETS > 1) ? $clog2(SETS) : 1;
	// reciprocal of the set count for the index reduction
	localparam int unsigned RSH     = 22;
	localparam int unsigned RECIP_I = (2 ** RSH) / SETS;
	localparam logic [RSH:0] RECIP  = RECIP_I[RSH:0];
	localparam int unsigned PW  = SET_W + RSH + 1;
	localparam int unsigned MW  = SET_W + 17;
	localparam logic [MW-1:0] SETS_W    = MW'(SETS);
	localparam logic [AW-1:0] LAST_ROW  = AW'(SETS - 1);
	localparam logic [RW-1:0] MAXV      = RW'(RRPV_MAX);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_QUO   = 5'b00100,
		ST_READ  = 5'b01000,
		ST_MOD   = 5'b10000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     row_addr_q;
	logic [SET_W-1:0]  set_q;
	logic [SET_W-1:0]  quo_q;
	cmd_t              cmd_q;
	logic              result_valid_q;
	logic [WAY_W-1:0]  victim_way_q;

	logic [PW-1:0]     quo_prod;
	logic [MW-1:0]     rem_raw;
	logic [MW-1:0]     rem_fix;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [ROW_W-1:0]  ram_rdata;
	logic [ROW_W-1:0]  row_new;
	logic [ROW_W-1:0]  row_max;
	logic [WAY_W-1:0]  victim;
	logic              accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// quotient estimate, exact or one short
	assign quo_prod = PW'(set_q) * PW'(RECIP);

	// remainder with one correction step
	always_comb begin
		rem_raw = MW'(set_q) - MW'(quo_q) * SETS_W;
		rem_fix = (rem_raw >= SETS_W) ? rem_raw - SETS_W : rem_raw;
	end

	// row image with every way at the maximum
	always_comb begin
		for (int w = 0; w < int'(WAYS); w++) begin
			row_max[w*RW +: RW] = MAXV;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ROW) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_QUO;
					end
				end
				ST_QUO: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					result_valid_q <= (cmd_q.kind == KIND_QUERY);
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command and address registers
	always_ff @(posedge clk) begin
		if (accept) begin
			set_q      <= set_index;
			cmd_q.kind <= kind;
			cmd_q.way  <= way;
			cmd_q.crit <= criticality;
		end
		if (state_q == ST_QUO) begin
			quo_q <= quo_prod[RSH +: SET_W];
		end
		if (state_q == ST_READ) begin
			row_addr_q <= rem_fix[AW-1:0];
		end
		if (state_q == ST_MOD) begin
			victim_way_q <= victim;
		end
	end

	// ram write: clearing pass or write-back of the modified row
	always_comb begin
		ram_we    = (state_q == ST_CLEAR) || (state_q == ST_MOD);
		ram_waddr = (state_q == ST_CLEAR) ? clr_q : row_addr_q;
		ram_wdata = (state_q == ST_CLEAR) ? row_max : row_new;
	end

	crrip_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rem_fix[AW-1:0]),
		.rdata (ram_rdata)
	);

	crrip_row_update #(
		.WAYS     (WAYS),
		.RRPV_MAX (RRPV_MAX)
	) u_update (
		.cmd     (cmd_q),
		.row_in  (ram_rdata),
		.row_out (row_new),
		.victim  (victim)
	);

	assign result_valid = result_valid_q;
	assign victim_way   = victim_way_q;

endmodule

`default_nettype wire

FILE: rtl/crrip_checker.sv
// port-level checks for the rrip replacement block, bound to the top level
`default_nettype none

module crrip_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] kind,
	input wire logic       result_valid
);

	import crrip_pkg::*;

	// an accepted beat makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepted beat");

	// a victim query gives its result after the quotient, read and modify states
	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_QUERY) |=> ##3 result_valid)
		else $error("victim query gave no result");

	// updates and unknown kinds give no result
	a_update_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind != KIND_QUERY) |=> ##3 !result_valid)
		else $error("result shown for a non-query beat");

	// a result lasts exactly one cycle
	a_result_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

endmodule

bind criticality_rrip_replacement crrip_checker u_checker (.*);

`default_nettype wire
